// ----- sv/iambic_keyer_mode_a_b_unit_defines.svh -----
// assertion macros for the iambic keyer checker
// expects clk and arst_n in the scope of use
`ifndef IAMBIC_KEYER_MODE_A_B_UNIT_DEFINES_SVH
`define IAMBIC_KEYER_MODE_A_B_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define IAK_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iambic keyer assertion failed");

// next-cycle implication, disabled in reset
`define IAK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iambic keyer assertion failed");

`endif

// ----- sv/iak_pkg.sv -----
// shared types and constants for the iambic keyer
// no dependencies
`timescale 1ns / 1ps

package iak_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_B_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIT_LEN = 2'd2;

	localparam logic [15:0] DIT_LEN_RESET = 16'd6000;

	typedef struct packed {
		logic        b_mode;
		logic        swap;
		logic [15:0] dit_len;
	} cfg_t;

	typedef struct packed {
		logic paddle_dit;
		logic paddle_dah;
		logic clear_memory;
	} in_t;

	typedef struct packed {
		logic key_down;
		logic key_edge;
		logic fwd_dit;
		logic fwd_dah;
		logic paddle_event;
	} out_t;

endpackage

// ----- sv/iak_if.sv -----
// valid/ready channel interfaces for paddle ticks and keyer results
// no dependencies
`timescale 1ns / 1ps

interface iak_in_if;
	logic valid;
	logic ready;
	logic paddle_dit;
	logic paddle_dah;
	logic clear_memory;

	modport source (output valid, output paddle_dit, output paddle_dah,
		output clear_memory, input ready);
	modport sink (input valid, input paddle_dit, input paddle_dah,
		input clear_memory, output ready);
endinterface

interface iak_out_if;
	logic valid;
	logic ready;
	logic key_down;
	logic key_edge;
	logic fwd_dit;
	logic fwd_dah;
	logic paddle_event;

	modport source (output valid, output key_down, output key_edge, output fwd_dit,
		output fwd_dah, output paddle_event, input ready);
	modport sink (input valid, input key_down, input key_edge, input fwd_dit,
		input fwd_dah, input paddle_event, output ready);
endinterface

// ----- sv/iak_cfg_regs.sv -----
// configuration registers of the iambic keyer
// depends on iak_pkg
`timescale 1ns / 1ps

module iak_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [iak_pkg::CFG_IDX_W-1:0]  index,
	input  logic [iak_pkg::CFG_DATA_W-1:0] data,
	output iak_pkg::cfg_t                   cfg
);

	iak_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.b_mode  <= 1'b0;
			cfg_q.swap    <= 1'b0;
			cfg_q.dit_len <= iak_pkg::DIT_LEN_RESET;
		end else if (we) begin
			case (index)
				iak_pkg::REG_B_MODE:  cfg_q.b_mode  <= data[0];
				iak_pkg::REG_SWAP:    cfg_q.swap    <= data[0];
				iak_pkg::REG_DIT_LEN: cfg_q.dit_len <= data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/iak_core.sv -----
// keyer element timing, paddle memories and result forming for one tick
// depends on iak_pkg
`timescale 1ns / 1ps

module iak_core #(
	parameter int UNIT_COUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  iak_pkg::cfg_t cfg,
	input  iak_pkg::in_t  item,
	output iak_pkg::out_t res
);

	localparam int UW = UNIT_COUNT_BITS;
	localparam int CW = UNIT_COUNT_BITS + 2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ON   = 2'd1;
	localparam logic [1:0] PH_GAP  = 2'd2;

	logic [1:0]    phase_q, n_phase;
	logic [CW-1:0] cnt_q, n_cnt;
	logic          cur_dah_q, n_cur_dah;
	logic          last_dah_q, n_last_dah;
	logic          dit_mem_q, n_dit_mem;
	logic          dah_mem_q, n_dah_mem;
	logic [1:0]    fwd_q, n_fwd;
	logic          key_q, n_key;

	logic            d, h;
	logic [UW+15:0]  len_ext;
	logic [UW-1:0]   unit;
	logic [CW-1:0]   unit_w, len, cnt_inc;
	logic            start, start_dah;

	assign d = cfg.swap ? item.paddle_dah : item.paddle_dit;
	assign h = cfg.swap ? item.paddle_dit : item.paddle_dah;

	// keep the low unit bits of the register, zero acts as one
	assign len_ext = {{UW{1'b0}}, cfg.dit_len};
	assign unit    = (len_ext[UW-1:0] == '0) ? UW'(1) : len_ext[UW-1:0];
	assign unit_w  = {2'b00, unit};
	assign len     = cur_dah_q ? ((unit_w << 1) + unit_w) : unit_w;
	assign cnt_inc = cnt_q + CW'(1);

	always_comb begin
		n_phase    = phase_q;
		n_cnt      = cnt_q;
		n_cur_dah  = cur_dah_q;
		n_last_dah = last_dah_q;
		n_dit_mem  = dit_mem_q;
		n_dah_mem  = dah_mem_q;
		n_fwd      = fwd_q;
		n_key      = key_q;
		start      = 1'b0;
		start_dah  = 1'b0;

		if (item.clear_memory) begin
			n_dit_mem = 1'b0;
			n_dah_mem = 1'b0;
		end

		case (phase_q)
			PH_IDLE: begin
				n_fwd = {h, d};
				if (d || h) begin
					start     = 1'b1;
					start_dah = !d;
				end
			end
			PH_ON: begin
				if (cfg.b_mode) begin
					if (!cur_dah_q && h) n_dah_mem = 1'b1;
					if (cur_dah_q && d) n_dit_mem = 1'b1;
				end
				if (cnt_inc >= len) begin
					n_key   = 1'b0;
					n_cnt   = '0;
					n_phase = PH_GAP;
				end else begin
					n_cnt = cnt_inc;
				end
			end
			default: begin
				// gap, and the unused code behaves the same
				if (cfg.b_mode) begin
					if (!cur_dah_q && h) n_dah_mem = 1'b1;
					if (cur_dah_q && d) n_dit_mem = 1'b1;
				end
				if (cnt_inc >= unit_w) begin
					n_fwd = {h, d};
					n_cnt = '0;
					if (n_dit_mem || n_dah_mem) begin
						start     = 1'b1;
						start_dah = !n_dit_mem;
						n_dit_mem = 1'b0;
						n_dah_mem = 1'b0;
					end else if (d || h) begin
						start     = 1'b1;
						start_dah = (d && h) ? !last_dah_q : !d;
					end else begin
						n_phase = PH_IDLE;
					end
				end else begin
					n_cnt = cnt_inc;
				end
			end
		endcase

		if (start) begin
			n_cur_dah  = start_dah;
			n_last_dah = start_dah;
			// opposite paddle already held at element start
			if (cfg.b_mode) begin
				if (!start_dah && h) n_dah_mem = 1'b1;
				if (start_dah && d) n_dit_mem = 1'b1;
			end
			n_key   = 1'b1;
			n_cnt   = '0;
			n_phase = PH_ON;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			cnt_q      <= '0;
			cur_dah_q  <= 1'b0;
			last_dah_q <= 1'b1;
			dit_mem_q  <= 1'b0;
			dah_mem_q  <= 1'b0;
			fwd_q      <= 2'b00;
			key_q      <= 1'b0;
		end else if (en) begin
			phase_q    <= n_phase;
			cnt_q      <= n_cnt;
			cur_dah_q  <= n_cur_dah;
			last_dah_q <= n_last_dah;
			dit_mem_q  <= n_dit_mem;
			dah_mem_q  <= n_dah_mem;
			fwd_q      <= n_fwd;
			key_q      <= n_key;
		end
	end

	assign res.key_down     = n_key;
	assign res.key_edge     = n_key ^ key_q;
	assign res.fwd_dit      = n_fwd[0];
	assign res.fwd_dah      = n_fwd[1];
	assign res.paddle_event = (n_fwd != fwd_q);

endmodule

// ----- sv/iambic_keyer_mode_a_b_unit.sv -----
// iambic keyer top level: input register, tick logic, result register
// a tick beat is held in the input register, and its result enters the result register when the beat advances
// throughput: one tick per cycle while the output is not stalled, set by the single-pass state update
// reset clears keyer state and the valid flags of both stages, registers return to defaults
// depends on iak_pkg, iak_if, iak_cfg_regs, iak_core
`timescale 1ns / 1ps

module iambic_keyer_mode_a_b_unit #(
	parameter int UNIT_COUNT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [iak_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [iak_pkg::CFG_DATA_W-1:0] cfg_data,
	iak_in_if.sink                          in_ch,
	iak_out_if.source                       out_ch
);

	iak_pkg::cfg_t cfg;
	iak_pkg::in_t  item_s1;
	iak_pkg::out_t res, res_s2;
	logic          valid_s1, valid_s2;
	logic          advance;

	iak_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// state steps only when the item moves into the result register
	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) valid_s1 <= in_ch.valid;
			if (advance) valid_s2 <= 1'b1;
			else if (out_ch.ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.paddle_dit   <= in_ch.paddle_dit;
			item_s1.paddle_dah   <= in_ch.paddle_dah;
			item_s1.clear_memory <= in_ch.clear_memory;
		end
		if (advance) res_s2 <= res;
	end

	iak_core #(
		.UNIT_COUNT_BITS (UNIT_COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res)
	);

	assign out_ch.valid        = valid_s2;
	assign out_ch.key_down     = res_s2.key_down;
	assign out_ch.key_edge     = res_s2.key_edge;
	assign out_ch.fwd_dit      = res_s2.fwd_dit;
	assign out_ch.fwd_dah      = res_s2.fwd_dah;
	assign out_ch.paddle_event = res_s2.paddle_event;

endmodule

// ----- sv/iak_checker.sv -----
// port-level checks for the iambic keyer, bound to the top level
// depends on iambic_keyer_mode_a_b_unit_defines.svh
`timescale 1ns / 1ps
`include "iambic_keyer_mode_a_b_unit_defines.svh"

module iak_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic key_down,
	input logic key_edge,
	input logic fwd_dit,
	input logic fwd_dah,
	input logic paddle_event
);

	logic       out_beat;
	logic       prev_key_q;
	logic [1:0] prev_fwd_q;
	logic [4:0] out_bits;

	assign out_beat = out_valid && out_ready;
	assign out_bits = {key_down, key_edge, fwd_dit, fwd_dah, paddle_event};

	// levels carried by the last delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q <= 1'b0;
			prev_fwd_q <= 2'b00;
		end else if (out_beat) begin
			prev_key_q <= key_down;
			prev_fwd_q <= {fwd_dah, fwd_dit};
		end
	end

	`IAK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`IAK_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_bits))
	`IAK_ASSERT_NOW(a_key_edge, out_beat, key_edge == (key_down != prev_key_q))
	`IAK_ASSERT_NOW(a_paddle_event, out_beat, paddle_event == ({fwd_dah, fwd_dit} != prev_fwd_q))

endmodule

bind iambic_keyer_mode_a_b_unit iak_checker u_iak_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.key_down     (out_ch.key_down),
	.key_edge     (out_ch.key_edge),
	.fwd_dit      (out_ch.fwd_dit),
	.fwd_dah      (out_ch.fwd_dah),
	.paddle_event (out_ch.paddle_event)
);

// ----- tb/sv/iambic_keyer_mode_a_b_unit_tb.sv -----
// testbench for the iambic keyer: paddle tick beats in, key and paddle results out
// predicts every result from its own keyer model and checks it field by field
// depends on iak_pkg, iak_if and iambic_keyer_mode_a_b_unit
`timescale 1ns / 1ps

module iambic_keyer_mode_a_b_unit_tb;

	localparam int CYCLE_LIMIT = 100000;
	localparam int PRINT_CAP   = 30;

	localparam logic [1:0] KEY_IDLE = 2'd0;
	localparam logic [1:0] KEY_ON   = 2'd1;
	localparam logic [1:0] KEY_GAP  = 2'd2;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [iak_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [iak_pkg::CFG_DATA_W-1:0] cfg_data;

	iak_in_if tick_ch ();
	iak_out_if key_ch ();

	iambic_keyer_mode_a_b_unit #(.UNIT_COUNT_BITS(16)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(tick_ch),
		.out_ch(key_ch)
	);

	// keyer model state and its copy of the registers
	iak_pkg::cfg_t cfg = '{b_mode: 1'b0, swap: 1'b0, dit_len: iak_pkg::DIT_LEN_RESET};
	logic [1:0]  key_phase = KEY_IDLE;
	logic [17:0] elem_ticks = '0;
	logic        cur_dah = 1'b0;
	logic        last_dah = 1'b1;
	logic        mem_dit = 1'b0;
	logic        mem_dah = 1'b0;
	logic [1:0]  fwd_paddles = 2'b00;
	logic        key_level = 1'b0;

	iak_pkg::out_t pending_results [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int ticks_sent = 0;
	int key_changes = 0;
	int paddle_changes = 0;
	int cycle_count = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// mode B: the paddle opposite to the element in progress arms its memory
	function automatic void latch_opposite(input logic d, input logic h);
		if (cfg.b_mode) begin
			if (!cur_dah && h)
				mem_dah = 1'b1;
			if (cur_dah && d)
				mem_dit = 1'b1;
		end
	endfunction

	function automatic void start_element(input logic is_dah, input logic d, input logic h);
		cur_dah = is_dah;
		last_dah = is_dah;
		latch_opposite(d, h);
		key_level = 1'b1;
		elem_ticks = '0;
		key_phase = KEY_ON;
	endfunction

	function automatic iak_pkg::out_t keyer_step(input iak_pkg::in_t t);
		logic d, h, old_key, nx;
		logic [1:0] old_fwd;
		logic [17:0] unit, len;
		d = cfg.swap ? t.paddle_dah : t.paddle_dit;
		h = cfg.swap ? t.paddle_dit : t.paddle_dah;
		old_key = key_level;
		old_fwd = fwd_paddles;
		unit = (cfg.dit_len == '0) ? 18'd1 : 18'(cfg.dit_len);
		if (t.clear_memory) begin
			mem_dit = 1'b0;
			mem_dah = 1'b0;
		end
		case (key_phase)
			KEY_IDLE: begin
				fwd_paddles = {h, d};
				if (d || h)
					start_element(!d, d, h);
			end
			KEY_ON: begin
				len = cur_dah ? 18'(3 * unit) : unit;
				latch_opposite(d, h);
				elem_ticks++;
				if (elem_ticks >= len) begin
					key_level = 1'b0;
					elem_ticks = '0;
					key_phase = KEY_GAP;
				end
			end
			default: begin
				latch_opposite(d, h);
				elem_ticks++;
				if (elem_ticks >= unit) begin
					fwd_paddles = {h, d};
					elem_ticks = '0;
					if (mem_dit || mem_dah) begin
						nx = !mem_dit;
						mem_dit = 1'b0;
						mem_dah = 1'b0;
						start_element(nx, d, h);
					end else if (d || h) begin
						// squeeze alternates against the last element
						nx = (d && h) ? !last_dah : !d;
						start_element(nx, d, h);
					end else begin
						key_phase = KEY_IDLE;
					end
				end
			end
		endcase
		keyer_step = '{key_down: key_level, key_edge: key_level != old_key,
			fwd_dit: fwd_paddles[0], fwd_dah: fwd_paddles[1],
			paddle_event: fwd_paddles != old_fwd};
	endfunction

	// valid is left high after the beat so back-to-back ticks need no deassertion between them
	task automatic send_tick(input logic d, input logic h, input logic c);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.paddle_dit <= d;
		tick_ch.paddle_dah <= h;
		tick_ch.clear_memory <= c;
		do
			@(posedge clk);
		while (!tick_ch.ready);
		pending_results.push_back(keyer_step('{paddle_dit: d, paddle_dah: h, clear_memory: c}));
		ticks_sent++;
	endtask

	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic set_config(input logic b_mode, input logic swap, input logic [15:0] dit_len);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= iak_pkg::REG_B_MODE;
		cfg_data <= iak_pkg::CFG_DATA_W'(b_mode);
		@(posedge clk);
		cfg.b_mode = b_mode;
		cfg_index <= iak_pkg::REG_SWAP;
		cfg_data <= iak_pkg::CFG_DATA_W'(swap);
		@(posedge clk);
		cfg.swap = swap;
		cfg_index <= iak_pkg::REG_DIT_LEN;
		cfg_data <= dit_len;
		@(posedge clk);
		cfg.dit_len = dit_len;
		cfg_we <= 1'b0;
	endtask

	// a dit tick, an idle tick and a dah tick at the reset unit length
	task automatic test_reset_defaults();
		send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0);
		send_tick(1'b0, 1'b1, 1'b0);
	endtask

	// zero unit acts as one; the element left from before ends at once
	task automatic test_zero_unit_squeeze();
		set_config(1'b0, 1'b0, 16'd0);
		repeat (2) send_tick(1'b0, 1'b0, 1'b0);
		repeat (4) send_tick(1'b1, 1'b1, 1'b0);
		repeat (5) send_tick(1'b0, 1'b0, 1'b0);
	endtask

	// swapped paddles, memory armed at element start, cleared mid element
	task automatic test_swap_mode_b_memory();
		set_config(1'b1, 1'b1, 16'd1);
		send_tick(1'b1, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0, 1'b1);
		repeat (2) send_tick(1'b0, 1'b0, 1'b0);
		send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b0, 1'b1, 1'b0);
		repeat (5) send_tick(1'b0, 1'b0, 1'b0);
	endtask

	task automatic test_mode_change_mid_element();
		set_config(1'b0, 1'b0, 16'd2);
		send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b0, 1'b1, 1'b0);
		set_config(1'b1, 1'b0, 16'd2);
		send_tick(1'b0, 1'b1, 1'b0);
		repeat (6) send_tick(1'b0, 1'b0, 1'b0);
	endtask

	// mostly held paddle patterns of element scale, some per-tick noise
	task automatic run_paddle_traffic(input int n_ticks);
		int sent, run_len, u;
		logic d, h;
		sent = 0;
		u = (cfg.dit_len == '0) ? 1 : int'(cfg.dit_len);
		while (sent < n_ticks) begin
			if ($urandom_range(149) == 0)
				wait_drained();
			d = 1'($urandom_range(1));
			h = 1'($urandom_range(1));
			if ($urandom_range(9) < 7) begin
				run_len = $urandom_range(5 * u + 2, 1);
				repeat (run_len) send_tick(d, h, $urandom_range(19) == 0);
			end else begin
				run_len = $urandom_range(6, 1);
				repeat (run_len)
					send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
						$urandom_range(3) == 0);
			end
			sent += run_len;
		end
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		logic [15:0] len;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(3))
				0: len = 16'd1;
				1: len = 16'd2;
				2: len = 16'($urandom_range(6, 3));
				default: len = $urandom_range(1) ? 16'd0 : 16'd3;
			endcase
			set_config(k[0], k[1], len);
			run_paddle_traffic(130);
		end
	endtask

	// one full dah and gap at a long unit: the counter must reach three units
	task automatic test_longest_unit();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(1'b0, 1'b0, 16'd40);
		send_tick(1'b0, 1'b1, 1'b0);
		repeat (4 * 40 + 4) send_tick(1'b0, 1'b0, 1'b0);
	endtask

	initial begin
		key_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			key_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		iak_pkg::out_t got, want;
		if (arst_n && key_ch.valid && key_ch.ready) begin
			got = {key_ch.key_down, key_ch.key_edge, key_ch.fwd_dit, key_ch.fwd_dah,
				key_ch.paddle_event};
			key_changes += got.key_edge;
			paddle_changes += got.paddle_event;
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with no tick outstanding");
			end else begin
				want = pending_results.pop_front();
				if (got.key_down !== want.key_down)
					report_mismatch($sformatf("key_down got %b want %b", got.key_down, want.key_down));
				if (got.key_edge !== want.key_edge)
					report_mismatch($sformatf("key_edge got %b want %b", got.key_edge, want.key_edge));
				if (got.fwd_dit !== want.fwd_dit)
					report_mismatch($sformatf("fwd_dit got %b want %b", got.fwd_dit, want.fwd_dit));
				if (got.fwd_dah !== want.fwd_dah)
					report_mismatch($sformatf("fwd_dah got %b want %b", got.fwd_dah, want.fwd_dah));
				if (got.paddle_event !== want.paddle_event)
					report_mismatch($sformatf("paddle_event got %b want %b", got.paddle_event,
						want.paddle_event));
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("watchdog: cycle limit reached with %0d results outstanding",
			pending_results.size());
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= iak_pkg::REG_B_MODE;
		cfg_data <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.paddle_dit <= 1'b0;
		tick_ch.paddle_dah <= 1'b0;
		tick_ch.clear_memory <= 1'b0;
		send_idle_pct = 12;
		recv_idle_pct = 71;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_unit_squeeze();
		test_swap_mode_b_memory();
		test_mode_change_mid_element();
		test_random_traffic(12, 71);
		test_random_traffic(71, 12);
		test_random_traffic(0, 0);
		test_longest_unit();

		wait_drained();
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		$display("covered %0d ticks: modes A and B, plain and swapped paddles, units 0 to 40",
			ticks_sent);
		$display("observed %0d key transitions and %0d paddle changes, %0d mismatches",
			key_changes, paddle_changes, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
